[rtl/core/itmr64_pkg.sv]
// itmr64_pkg: shared types and constants for the 64-bit interval timer
// no dependencies; imported by every module of the timer
`default_nettype none

package itmr64_pkg;

    localparam int CNT_W      = 64;
    localparam int HALF_W     = 16;
    localparam int NUM_HALF   = CNT_W / HALF_W;
    localparam int HALF_IDX_W = $clog2(NUM_HALF);

    localparam logic [CNT_W-1:0] PERIOD_RESET  = CNT_W'(10000);
    localparam logic [1:0]       CTL_READ_MASK = 2'h3;

    // register offsets
    localparam logic [3:0] ADDR_STATUS  = 4'd0;
    localparam logic [3:0] ADDR_CONTROL = 4'd1;
    localparam logic [3:0] ADDR_PERIOD0 = 4'd2;
    localparam logic [3:0] ADDR_PERIOD3 = 4'd5;
    localparam logic [3:0] ADDR_SNAP0   = 4'd6;
    localparam logic [3:0] ADDR_SNAP3   = 4'd9;

    // control register bits
    localparam int CTL_ITO   = 0;
    localparam int CTL_CONT  = 1;
    localparam int CTL_START = 2;
    localparam int CTL_STOP  = 3;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } op_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [3:0]        addr;
        logic [HALF_W-1:0] wdata;
    } req_t;

    typedef struct packed {
        logic [HALF_W-1:0] rdata;
        logic              irq;
    } rsp_t;

endpackage

`default_nettype wire

[rtl/core/itmr64_core.sv]
// itmr64_core: timer state registers and the single-pass request execution
// depends on itmr64_pkg
`default_nettype none

module itmr64_core
    import itmr64_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic commit,
    input  wire req_t req,
    output rsp_t      rsp
);

    logic [CNT_W-1:0] period_reg, period_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] snap_reg, snap_next;
    logic ito_reg, ito_next;
    logic cont_reg, cont_next;
    logic to_reg, to_next;
    logic run_reg, run_next;
    logic irq_reg, irq_next;

    logic [CNT_W-1:0]      load_val;
    logic [CNT_W-1:0]      count_dec;
    logic [3:0]            addr_off;
    logic [HALF_IDX_W-1:0] half_idx;
    logic [HALF_W-1:0]     rdata;

    assign load_val  = (period_reg == '0) ? CNT_W'(1) : period_reg;
    assign count_dec = (count_reg != '0) ? count_reg - CNT_W'(1) : count_reg;

    always_comb
    begin
        if (req.addr >= ADDR_SNAP0)
            addr_off = req.addr - ADDR_SNAP0;
        else
            addr_off = req.addr - ADDR_PERIOD0;
        half_idx = addr_off[HALF_IDX_W-1:0];
    end

    always_comb
    begin
        period_next = period_reg;
        count_next  = count_reg;
        snap_next   = snap_reg;
        ito_next    = ito_reg;
        cont_next   = cont_reg;
        to_next     = to_reg;
        run_next    = run_reg;
        irq_next    = irq_reg;
        rdata       = '0;
        unique case (req.op)
            OP_TICK:
            begin
                if (run_reg)
                begin
                    count_next = count_dec;
                    if (count_dec == '0)
                    begin
                        if (ito_reg)
                        begin
                            to_next  = 1'b1;
                            irq_next = 1'b1;
                        end
                        if (cont_reg)
                            count_next = load_val;
                        else
                            run_next = 1'b0;
                    end
                end
            end
            OP_READ:
            begin
                if (req.addr == ADDR_STATUS)
                    rdata = HALF_W'({run_reg, to_reg});
                else if (req.addr == ADDR_CONTROL)
                    rdata = HALF_W'({cont_reg, ito_reg} & CTL_READ_MASK);
                else if (req.addr >= ADDR_PERIOD0 && req.addr <= ADDR_PERIOD3)
                    rdata = period_reg[half_idx*HALF_W +: HALF_W];
                else if (req.addr >= ADDR_SNAP0 && req.addr <= ADDR_SNAP3)
                    rdata = snap_reg[half_idx*HALF_W +: HALF_W];
            end
            OP_WRITE:
            begin
                if (req.addr == ADDR_STATUS)
                begin
                    to_next = req.wdata[0];
                    if (!req.wdata[0])
                        irq_next = 1'b0;
                end
                else if (req.addr == ADDR_CONTROL)
                begin
                    ito_next  = req.wdata[CTL_ITO];
                    cont_next = req.wdata[CTL_CONT];
                    // start is applied before stop
                    if (req.wdata[CTL_START] && !run_reg)
                    begin
                        run_next   = 1'b1;
                        count_next = load_val;
                    end
                    if (req.wdata[CTL_STOP] && (run_reg || req.wdata[CTL_START]))
                        run_next = 1'b0;
                end
                else if (req.addr >= ADDR_PERIOD0 && req.addr <= ADDR_PERIOD3)
                    period_next[half_idx*HALF_W +: HALF_W] = req.wdata;
                else if (req.addr >= ADDR_SNAP0 && req.addr <= ADDR_SNAP3)
                    snap_next = count_reg;
            end
            default:
            begin
                rdata = '0;
            end
        endcase
    end

    assign rsp.rdata = rdata;
    assign rsp.irq   = irq_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
            count_reg  <= '0;
            snap_reg   <= '0;
            ito_reg    <= 1'b0;
            cont_reg   <= 1'b0;
            to_reg     <= 1'b0;
            run_reg    <= 1'b0;
            irq_reg    <= 1'b0;
        end
        else if (commit)
        begin
            period_reg <= period_next;
            count_reg  <= count_next;
            snap_reg   <= snap_next;
            ito_reg    <= ito_next;
            cont_reg   <= cont_next;
            to_reg     <= to_next;
            run_reg    <= run_next;
            irq_reg    <= irq_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/interval_timer_64bit_top.sv]
// 64-bit interval timer with snapshot
// depends on itmr64_pkg and itmr64_core
//
// usage
//   req channel: one request per item, either a clock tick (op tick) or a
//   register access (op read / write, addr, wdata). rsp channel: one
//   response per request, in order, carrying rdata (zero for ticks and
//   writes) and the interrupt level after the request.
// datapath and throughput
//   a request is held in an input register, executed against the timer
//   state in one pass of combinational logic and written to the response
//   register, which raises rsp_valid. One request per cycle is taken
//   while the response is not stalled by rsp_ready low; the 64-bit
//   decrement and zero compare is the longest path.
// reset
//   rst_n clears both pipeline stages, the counter, snapshot, flags and
//   control bits, and loads the period with 10000.
// stalls
//   while rsp_ready is low the response holds; one further request can sit
//   in the input register, after which req_ready drops.
`default_nettype none

module interval_timer_64bit_top
    import itmr64_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    req_t item_reg;
    logic item_valid_reg;
    rsp_t rsp_reg;
    logic rsp_valid_reg;
    rsp_t core_rsp;
    logic advance;

    assign advance   = item_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !item_valid_reg || advance;

    itmr64_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (advance),
        .req    (item_reg),
        .rsp    (core_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (req_ready)
                item_valid_reg <= req_valid;
            if (advance)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            item_reg <= req;
        if (advance)
            rsp_reg <= core_rsp;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

[rtl/core/itmr64_checker.sv]
// itmr64_checker: port-level assertions for the interval timer
// depends on itmr64_pkg; bound to interval_timer_64bit_top
`default_nettype none

module itmr64_checker
    import itmr64_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_ready,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire rsp_t rsp
);

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // requests are only refused when a response is waiting
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid)
        else $error("request refused with empty response stage");

    // a fresh response means the output stage was free, so requests were open
    a_rose_after_ready: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_ready))
        else $error("response appeared while input was blocked");

    // a request accepted with the pipe drained reaches rsp_valid via the input and response registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && !rsp_valid && $past(req_ready && !req_valid)
        |=> ##1 rsp_valid)
        else $error("response missing two cycles after request");

endmodule

bind interval_timer_64bit_top itmr64_checker u_itmr64_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire

[tb/sv/interval_timer_64bit_top_tb.sv]
`timescale 1ns / 1ps
// testbench for interval_timer_64bit_top: directed and random requests, checked
// against a cycle-free model of the timer registers kept alongside
// depends on itmr64_pkg and the timer rtl

module interval_timer_64bit_top_tb;
    import itmr64_pkg::*;

    localparam logic [1:0]        OP_UNUSED      = 2'd3;
    localparam logic [3:0]        ADDR_UNUSED_LO = 4'd10;
    localparam logic [3:0]        ADDR_UNUSED_HI = 4'd15;
    localparam logic [HALF_W-1:0] STS_TO         = 16'h0001;
    localparam logic [HALF_W-1:0] STS_RUN        = 16'h0002;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    interval_timer_64bit_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // timer state as the requests should leave it
    logic [CNT_W-1:0] period_q;
    logic [CNT_W-1:0] remain_q;
    logic [CNT_W-1:0] snap_q;
    logic             ito_q;
    logic             cont_q;
    logic             to_q;
    logic             run_q;
    logic             irq_q;

    rsp_t pending_rsp[$];
    bit   no_idle;
    int   n_errors;
    int   n_checked;
    int   n_counted;
    int   n_ticks;
    int   n_reads;
    int   n_writes;
    int   n_expiries;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge clk)
    begin
        rsp_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 21);
    end

    function automatic logic [CNT_W-1:0] reload_value();
        return (period_q == '0) ? CNT_W'(1) : period_q;
    endfunction

    function automatic rsp_t timer_apply(req_t r);
        rsp_t o;
        int   k;
        o.rdata = '0;
        case (r.op)
            OP_TICK:
            begin
                if (run_q)
                begin
                    if (remain_q != '0)
                        remain_q = remain_q - 1'b1;
                    if (remain_q == '0)
                    begin
                        n_expiries++;
                        if (ito_q)
                        begin
                            to_q  = 1'b1;
                            irq_q = 1'b1;
                        end
                        if (cont_q)
                            remain_q = reload_value();
                        else
                            run_q = 1'b0;
                    end
                end
            end
            OP_READ:
            begin
                if (r.addr == ADDR_STATUS)
                    o.rdata = HALF_W'({run_q, to_q});
                else if (r.addr == ADDR_CONTROL)
                    o.rdata = HALF_W'({cont_q, ito_q} & CTL_READ_MASK);
                else if (r.addr >= ADDR_PERIOD0 && r.addr <= ADDR_PERIOD3)
                begin
                    k = int'(r.addr - ADDR_PERIOD0);
                    o.rdata = period_q[k*HALF_W +: HALF_W];
                end
                else if (r.addr >= ADDR_SNAP0 && r.addr <= ADDR_SNAP3)
                begin
                    k = int'(r.addr - ADDR_SNAP0);
                    o.rdata = snap_q[k*HALF_W +: HALF_W];
                end
            end
            OP_WRITE:
            begin
                if (r.addr == ADDR_STATUS)
                begin
                    to_q = r.wdata[0];
                    if (!r.wdata[0])
                        irq_q = 1'b0;
                end
                else if (r.addr == ADDR_CONTROL)
                begin
                    ito_q  = r.wdata[CTL_ITO];
                    cont_q = r.wdata[CTL_CONT];
                    // start before stop, so both together leave it stopped
                    if (r.wdata[CTL_START] && !run_q)
                    begin
                        run_q    = 1'b1;
                        remain_q = reload_value();
                    end
                    if (r.wdata[CTL_STOP])
                        run_q = 1'b0;
                end
                else if (r.addr >= ADDR_PERIOD0 && r.addr <= ADDR_PERIOD3)
                begin
                    k = int'(r.addr - ADDR_PERIOD0);
                    period_q[k*HALF_W +: HALF_W] = r.wdata;
                end
                else if (r.addr >= ADDR_SNAP0 && r.addr <= ADDR_SNAP3)
                    snap_q = remain_q;
            end
            default: ;
        endcase
        o.irq = irq_q;
        return o;
    endfunction

    function automatic req_t make_req(logic [1:0] op, logic [3:0] addr,
                                      logic [HALF_W-1:0] wdata);
        req_t r;
        r.op    = op;
        r.addr  = addr;
        r.wdata = wdata;
        return r;
    endfunction

    function automatic logic [HALF_W-1:0] ctl_word(bit ito, bit cont, bit start, bit stop);
        logic [HALF_W-1:0] w;
        w = '0;
        w[CTL_ITO]   = ito;
        w[CTL_CONT]  = cont;
        w[CTL_START] = start;
        w[CTL_STOP]  = stop;
        return w;
    endfunction

    task automatic note_mismatch(string what, logic [HALF_W-1:0] want,
                                 logic [HALF_W-1:0] got);
        n_errors++;
        if (n_errors <= 10)
            $display("mismatch in %s: expected 0x%04h, got 0x%04h", what, want, got);
    endtask

    // holds valid from one request to the next unless an idle gap is taken
    task automatic send_req(req_t r);
        if (!no_idle && $urandom_range(99) < 21)
        begin
            req_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 21);
        end
        req       <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        n_counted++;
        case (r.op)
            OP_TICK:  n_ticks++;
            OP_READ:  n_reads++;
            OP_WRITE: n_writes++;
            default: ;
        endcase
        pending_rsp.push_back(timer_apply(r));
    endtask

    task automatic reg_write(logic [3:0] addr, logic [HALF_W-1:0] data);
        send_req(make_req(OP_WRITE, addr, data));
    endtask

    task automatic reg_read(logic [3:0] addr);
        send_req(make_req(OP_READ, addr, '0));
    endtask

    task automatic tick_once();
        send_req(make_req(OP_TICK, '0, '0));
    endtask

    task automatic wait_drain();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending_rsp.size() != 0);
    endtask

    always @(posedge clk)
    begin : rsp_check
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
                note_mismatch("unrequested response", '0, rsp.rdata);
            else
            begin
                want = pending_rsp.pop_front();
                n_checked++;
                if (rsp.rdata !== want.rdata)
                    note_mismatch("rdata", want.rdata, rsp.rdata);
                if (rsp.irq !== want.irq)
                    note_mismatch("irq", HALF_W'(want.irq), HALF_W'(rsp.irq));
            end
        end
    end

    task automatic test_reset_values();
        reg_read(ADDR_STATUS);
        reg_read(ADDR_PERIOD0);
    endtask

    task automatic test_period_halves();
        reg_write(ADDR_PERIOD0, 16'hFFFF);
        reg_write(ADDR_PERIOD3, 16'hFFFF);
        reg_read(ADDR_PERIOD3);
        reg_write(ADDR_PERIOD0, 16'h0000);
        reg_write(ADDR_PERIOD3, 16'h0000);
    endtask

    // period of zero loads one, so the first tick expires
    task automatic test_zero_period_one_shot();
        reg_write(ADDR_CONTROL, ctl_word(1, 0, 1, 0));
        tick_once();
        reg_read(ADDR_STATUS);
    endtask

    task automatic test_irq_clear();
        reg_write(ADDR_STATUS, STS_TO | STS_RUN);
        reg_write(ADDR_STATUS, '0);
        reg_write(ADDR_STATUS, STS_TO);
    endtask

    task automatic test_continuous_reload();
        reg_write(ADDR_PERIOD0, 16'd3);
        reg_write(ADDR_CONTROL, ctl_word(0, 1, 1, 0));
        reg_write(ADDR_CONTROL, ctl_word(0, 1, 1, 0));
        repeat (4) tick_once();
    endtask

    task automatic test_snapshot();
        reg_write(ADDR_SNAP3, 16'hFFFF);
        reg_read(ADDR_SNAP0);
        reg_read(ADDR_CONTROL);
    endtask

    task automatic test_stop_and_start();
        reg_write(ADDR_CONTROL, ctl_word(0, 0, 0, 1));
        reg_write(ADDR_CONTROL, ctl_word(0, 0, 0, 1));
        reg_write(ADDR_CONTROL, ctl_word(1, 1, 1, 1));
        tick_once();
    endtask

    task automatic test_unused_space();
        reg_read(ADDR_UNUSED_HI);
        reg_write(ADDR_UNUSED_LO, 16'hFFFF);
        send_req(make_req(OP_UNUSED, ADDR_STATUS, 16'hFFFF));
    endtask

    // stop, program a period (short when the upper halves are cleared), usually start, and run with accesses mixed in
    task automatic run_timer_sequence(bit well_formed);
        int unsigned p;
        int unsigned steps;
        int unsigned pick;
        int          i;
        p = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(12);
        reg_write(ADDR_CONTROL, ctl_word(1'($urandom_range(1)), 1'($urandom_range(1)), 0, 1));
        reg_write(ADDR_PERIOD0, HALF_W'(p));
        if (well_formed || $urandom_range(1))
            for (i = 1; i < NUM_HALF; i++)
                reg_write(4'(ADDR_PERIOD0 + i), '0);
        reg_write(ADDR_CONTROL, ctl_word(1'($urandom_range(1)), 1'($urandom_range(1)),
                                         well_formed || $urandom_range(1),
                                         $urandom_range(15) == 0));
        steps = $urandom_range(2 * p + 4);
        for (i = 0; i < int'(steps); i++)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                tick_once();
            else if (pick < 76)
                reg_read(ADDR_STATUS);
            else if (pick < 80)
                reg_read(ADDR_CONTROL);
            else if (pick < 86)
                reg_write(4'(ADDR_SNAP0 + $urandom_range(3)), HALF_W'($urandom));
            else if (pick < 92)
                reg_read(4'(ADDR_SNAP0 + $urandom_range(3)));
            else if (pick < 97)
                reg_write(ADDR_STATUS, HALF_W'($urandom));
            else
                reg_read(4'(ADDR_PERIOD0 + $urandom_range(3)));
        end
    endtask

    // full-width period so the snapshot carries bits in every halfword
    task automatic run_wide_count_check();
        int i;
        reg_write(ADDR_CONTROL, ctl_word(0, 0, 0, 1));
        for (i = 0; i < NUM_HALF; i++)
            reg_write(4'(ADDR_PERIOD0 + i), HALF_W'($urandom));
        reg_write(ADDR_CONTROL, ctl_word(1'($urandom_range(1)), 1'($urandom_range(1)), 1, 0));
        repeat ($urandom_range(1, 5)) tick_once();
        reg_write(4'(ADDR_SNAP0 + $urandom_range(3)), HALF_W'($urandom));
        for (i = 0; i < NUM_HALF; i++)
            reg_read(4'(ADDR_SNAP0 + i));
        for (i = 0; i < NUM_HALF; i++)
            reg_read(4'(ADDR_PERIOD0 + i));
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 6))
            send_req(make_req(2'($urandom_range(3)), 4'($urandom_range(15)),
                              HALF_W'($urandom)));
    endtask

    task automatic run_mixed_traffic(int quota, bit with_pause);
        int  start;
        int  sel;
        bit  paused;
        start  = n_counted;
        paused = 1'b0;
        while (n_counted - start < quota)
        begin
            sel = $urandom_range(99);
            if (sel < 65)
                run_timer_sequence(1'b1);
            else if (sel < 75)
                run_wide_count_check();
            else if (sel < 85)
                run_timer_sequence(1'b0);
            else
                send_noise();
            if (with_pause && !paused && n_counted - start > quota / 2)
            begin
                wait_drain();
                paused = 1'b1;
            end
        end
    endtask

    task automatic test_random_traffic();
        run_mixed_traffic(290, 1'b1);
    endtask

    // back to back requests and an always-ready receiver
    task automatic test_streaming();
        no_idle = 1'b1;
        run_mixed_traffic(110, 1'b0);
        no_idle = 1'b0;
    endtask

    initial
    begin
        req_valid <= 1'b0;
        req       <= '0;
        rst_n     <= 1'b0;
        no_idle    = 1'b0;
        period_q   = PERIOD_RESET;
        remain_q   = '0;
        snap_q     = '0;
        ito_q      = 1'b0;
        cont_q     = 1'b0;
        to_q       = 1'b0;
        run_q      = 1'b0;
        irq_q      = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_period_halves();
        test_zero_period_one_shot();
        test_irq_clear();
        test_continuous_reload();
        test_snapshot();
        test_stop_and_start();
        test_unused_space();
        test_random_traffic();
        test_streaming();

        wait_drain();
        repeat (10) @(posedge clk);
        if (pending_rsp.size() != 0)
            note_mismatch("responses still outstanding", '0, HALF_W'(pending_rsp.size()));

        $display("covered %0d requests: %0d ticks, %0d reads, %0d writes, %0d responses checked",
                 n_ticks + n_reads + n_writes, n_ticks, n_reads, n_writes, n_checked);
        $display("counter reached zero %0d times, %0d errors", n_expiries, n_errors);
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[interval_timer_64bit_top.f]
rtl/core/itmr64_pkg.sv
rtl/core/itmr64_core.sv
rtl/core/interval_timer_64bit_top.sv
rtl/core/itmr64_checker.sv
tb/sv/interval_timer_64bit_top_tb.sv
